/* src/sbad_pkg.sv */
// sbad_pkg: widths, character codes, sequencer states and control struct
// for the signed binary to ascii decimal core; no dependencies
`default_nettype none

package sbad_pkg;

   localparam int VALUE_WIDTH = 32;
   // decimal digits needed for magnitudes up to 2^(VALUE_WIDTH-1)
   localparam int DIGITS      = (VALUE_WIDTH * 77) / 256 + 1;
   localparam int BCD_WIDTH   = DIGITS * 4;
   localparam int PTR_WIDTH   = $clog2(DIGITS);
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
   localparam int CHAR_WIDTH  = 6;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_NINE  = 6'd57;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 6'd45;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } dab_ctrl_type;

endpackage

`default_nettype wire

/* src/signed_binary_to_ascii_decimal_core.sv */
// signed_binary_to_ascii_decimal_core: top level, sequencer and character output
// depends on sbad_pkg and sbad_dabble
//
//   channel   ports                                  handshake
//   request   req_value                              start && !busy
//   response  rsp_char_code, rsp_last_char           rsp_valid strobe, one cycle
//
// the accept edge loads the magnitude, then the double dabble unit shifts once per value bit
// (32 bits by default), then leading zeros are skipped down to an n digit result,
// then one cycle per character (minus sign and n digits, up to 11 characters).
// busy is high from the accept edge until the last character has been shown.
// synchronous reset returns the sequencer to idle; the receiver cannot stall.
`default_nettype none

module signed_binary_to_ascii_decimal_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [sbad_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                  rsp_valid,
   output logic      [sbad_pkg::CHAR_WIDTH-1:0]  rsp_char_code,
   output logic                                  rsp_last_char
);
   import sbad_pkg::*;

   state_type              state_ff, state_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [PTR_WIDTH-1:0]   ptr_ff, ptr_in;
   logic                   neg_ff, neg_in;
   dab_ctrl_type           ctrl;
   logic [BCD_WIDTH-1:0]   bcd;
   logic [3:0]             digit;

   sbad_dabble u_dabble (
      .clock (clock),
      .ctrl  (ctrl),
      .value (req_value),
      .bcd   (bcd)
   );

   assign digit = bcd[ptr_ff*4 +: 4];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ptr_ff   <= '0;
         neg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ptr_ff   <= ptr_in;
         neg_ff   <= neg_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      neg_in        = neg_ff;
      ctrl          = '0;
      busy          = 1'b1;
      rsp_valid     = 1'b0;
      rsp_char_code = ASCII_ZERO + {2'b00, digit};
      rsp_last_char = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctrl.load = 1'b1;
               neg_in    = req_value[VALUE_WIDTH-1];
               cnt_in    = '0;
               state_in  = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            ctrl.shift = 1'b1;
            cnt_in     = cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
               ptr_in   = PTR_WIDTH'(DIGITS - 1);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (digit == 4'd0 && ptr_ff != '0) begin
               ptr_in = ptr_ff - PTR_WIDTH'(1);
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_SIGN: begin
            rsp_valid     = 1'b1;
            rsp_char_code = ASCII_MINUS;
            state_in      = ST_DIGITS;
         end
         ST_DIGITS: begin
            rsp_valid     = 1'b1;
            rsp_last_char = (ptr_ff == '0);
            if (ptr_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff - PTR_WIDTH'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/sbad_dabble.sv */
// sbad_dabble: shift-and-add-3 unit holding the magnitude and bcd digits
// depends on sbad_pkg
`default_nettype none

module sbad_dabble (
   input  wire logic                             clock,
   input  wire sbad_pkg::dab_ctrl_type           ctrl,
   input  wire logic [sbad_pkg::VALUE_WIDTH-1:0] value,
   output logic      [sbad_pkg::BCD_WIDTH-1:0]   bcd
);
   import sbad_pkg::*;

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0]   bcd_adj;
   logic [VALUE_WIDTH-1:0] mag;

   // two's complement magnitude, exact for the most negative value
   assign mag = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = mag;
         bcd_in = '0;
      end else if (ctrl.shift) begin
         bcd_in = {bcd_adj[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd = bcd_ff;

endmodule

`default_nettype wire

/* src/sbad_checker.sv */
// sbad_checker: port-level assertions for the signed binary to ascii decimal core
// depends on sbad_pkg; bound to signed_binary_to_ascii_decimal_core
`default_nettype none

module sbad_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             rsp_valid,
   input wire logic [sbad_pkg::CHAR_WIDTH-1:0]  rsp_char_code,
   input wire logic                             rsp_last_char
);
   import sbad_pkg::*;

   // characters only while a beat is in work
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |=> !busy)
      else $error("busy after last character");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_code == ASCII_MINUS ||
                     (rsp_char_code >= ASCII_ZERO && rsp_char_code <= ASCII_NINE)))
      else $error("character code out of range");

   a_fell_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid && rsp_last_char))
      else $error("busy dropped without last character");

endmodule

bind signed_binary_to_ascii_decimal_core sbad_checker u_sbad_checker (.*);

`default_nettype wire
